// ===== sv/rgb_frame_buffer_blend_scanout_unit_assert.svh =====
// Assertion macros shared by the frame buffer RTL.
`ifndef RGB_FRAME_BUFFER_BLEND_SCANOUT_UNIT_ASSERT_SVH
`define RGB_FRAME_BUFFER_BLEND_SCANOUT_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check cons in the same cycle as ante.
`define RFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check cons in the cycle after ante.
`define RFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RFB_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RFB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/rgbfb_pkg.sv =====
// Package: geometry, mode codes and beat types of the frame buffer.
`timescale 1ns / 1ps
package rgbfb_pkg;

  localparam int ROWS    = 8;
  localparam int COLS    = 8;
  localparam int NPIX    = ROWS * COLS;
  localparam int PIX_W   = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int PIXC_W  = $clog2(NPIX + 1);

  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_BLEND  = 2'd1;
  localparam logic [1:0] MODE_BRIGHT = 2'd2;
  localparam logic [1:0] MODE_SCAN   = 2'd3;

  localparam logic [7:0] BRIGHT_RST  = 8'd100;
  localparam logic [7:0] BYTE_ESC    = 8'd255;
  localparam logic [7:0] BYTE_CLAMP  = 8'd254;
  localparam logic [7:0] BYTE_CMD    = 8'd1;
  localparam logic [3:0] ESC_COUNT   = 4'd9;
  localparam logic [3:0] BRIGHT_LAST = 4'd10;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] row;
    logic [3:0] col;
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       last;
  } out_item_t;

endpackage

// ===== sv/rgb_frame_buffer_blend_scanout_unit.sv =====
// Top level: RGB frame store with pixel set, alpha blend and serial scan-out.
// Timing: a set is written at the accept edge and never sets busy; a blend is busy
//   in S_BLEND_MUL and S_BLEND_WR and writes back as it leaves S_BLEND_WR; a scan byte
//   is read in S_SCAN_RD and registered onto its out_strobe beat; a terminator beat is
//   registered at the accept edge. Throughput: one item per cycle for set and terminator;
//   a scan byte, a blend or a brightness command keeps busy high until it is through, so
//   no new item is taken before then; in S_BRIGHT the command sends one beat a cycle.
// The registered read port of the pixel memory shapes the scan and blend timing.
// Reset (rst_n low, synchronous) clears all pixel valid bits, so the store reads zero,
//   rewinds the scan to the first byte and loads brightness with 100; beats never stall.
`timescale 1ns / 1ps
`include "rgb_frame_buffer_blend_scanout_unit_assert.svh"
module rgb_frame_buffer_blend_scanout_unit
  import rgbfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_strobe,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BLEND_MUL,
    S_BLEND_WR,
    S_SCAN_RD,
    S_BRIGHT
  } state_t;

  // Control and output registers
  state_t             st_r, st_nxt;
  logic [PIXC_W-1:0]  pix_r, pix_nxt;     // pixel of the next scan byte
  logic [1:0]         comp_r, comp_nxt;   // component: 0 red, 1 green, 2 blue
  logic [3:0]         bcnt_r, bcnt_nxt;   // brightness command beat counter
  logic [7:0]         brt_r;
  logic               out_strobe_r, out_strobe_nxt;
  out_item_t          out_data_r, out_data_nxt;

  // Item holding registers (payload, no reset)
  in_item_t           item_r;
  logic [PIX_W-1:0]   idx_r;
  logic [15:0]        prod_old_r [3];
  logic [15:0]        prod_new_r [3];

  // Pixel memory
  logic [23:0]        mem [NPIX];
  logic [NPIX-1:0]    vld_r;
  logic [23:0]        rd_data_r;
  logic               rd_vld_r;
  logic               mem_we;
  logic [PIX_W-1:0]   mem_waddr;
  logic [23:0]        mem_wdata;
  logic [PIX_W-1:0]   mem_raddr;

  logic               in_acc;
  logic               in_range;
  logic [7:0]         idx_full;
  logic [PIX_W-1:0]   idx_in;
  logic [23:0]        old_pix;
  logic [7:0]         old_c [3];
  logic [7:0]         new_c [3];
  logic [15:0]        mix_sum [3];
  logic [7:0]         scan_c;

  assign in_acc   = start && !busy;
  assign busy     = (st_r != S_IDLE);
  assign in_range = ({1'b0, in_data.row} < 5'(ROWS)) && ({1'b0, in_data.col} < 5'(COLS));
  assign idx_full = ({4'b0, in_data.row} * 8'(COLS)) + {4'b0, in_data.col};
  assign idx_in   = idx_full[PIX_W-1:0];

  // Unwritten pixels read as zero
  assign old_pix  = rd_vld_r ? rd_data_r : 24'd0;
  assign old_c[0] = old_pix[23:16];
  assign old_c[1] = old_pix[15:8];
  assign old_c[2] = old_pix[7:0];
  assign new_c[0] = item_r.red;
  assign new_c[1] = item_r.green;
  assign new_c[2] = item_r.blue;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mix_sum[i] = prod_old_r[i] + prod_new_r[i];
    end
  end

  always_comb begin
    case (comp_r)
      2'd0:    scan_c = old_pix[23:16];
      2'd1:    scan_c = old_pix[15:8];
      default: scan_c = old_pix[7:0];
    endcase
  end

  // Next-state and memory control
  always_comb begin
    st_nxt         = st_r;
    pix_nxt        = pix_r;
    comp_nxt       = comp_r;
    bcnt_nxt       = bcnt_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_in;
    mem_wdata      = {in_data.red, in_data.green, in_data.blue};
    mem_raddr      = (in_data.mode == MODE_SCAN) ? pix_r[PIX_W-1:0] : idx_in;
    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.mode)
            MODE_SET: begin
              // Write straight through; out-of-range pixels drop the item
              mem_we = in_range;
            end
            MODE_BLEND: begin
              if (in_range) begin
                st_nxt = S_BLEND_MUL;
              end
            end
            MODE_BRIGHT: begin
              bcnt_nxt = 4'd0;
              st_nxt   = S_BRIGHT;
            end
            default: begin
              if (pix_r == PIXC_W'(NPIX)) begin
                // Frame done: send the terminator and rewind
                out_strobe_nxt         = 1'b1;
                out_data_nxt.tx_byte   = BYTE_ESC;
                out_data_nxt.frame_end = 1'b1;
                out_data_nxt.last      = 1'b1;
                pix_nxt                = '0;
                comp_nxt               = 2'd0;
              end else begin
                st_nxt = S_SCAN_RD;
              end
            end
          endcase
        end
      end
      S_BLEND_MUL: begin
        st_nxt = S_BLEND_WR;
      end
      S_BLEND_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = {mix_sum[0][15:8], mix_sum[1][15:8], mix_sum[2][15:8]};
        st_nxt    = S_IDLE;
      end
      S_SCAN_RD: begin
        out_strobe_nxt         = 1'b1;
        out_data_nxt.tx_byte   = (scan_c == BYTE_ESC) ? BYTE_CLAMP : scan_c;
        out_data_nxt.frame_end = 1'b0;
        out_data_nxt.last      = 1'b1;
        if (comp_r == 2'd2) begin
          comp_nxt = 2'd0;
          pix_nxt  = pix_r + PIXC_W'(1);
        end else begin
          comp_nxt = comp_r + 2'd1;
        end
        st_nxt = S_IDLE;
      end
      S_BRIGHT: begin
        out_strobe_nxt         = 1'b1;
        out_data_nxt.frame_end = 1'b0;
        out_data_nxt.last      = (bcnt_r == BRIGHT_LAST);
        if (bcnt_r < ESC_COUNT) begin
          out_data_nxt.tx_byte = BYTE_ESC;
        end else if (bcnt_r == ESC_COUNT) begin
          out_data_nxt.tx_byte = BYTE_CMD;
        end else begin
          out_data_nxt.tx_byte = brt_r;
        end
        bcnt_nxt = bcnt_r + 4'd1;
        if (bcnt_r == BRIGHT_LAST) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      pix_r        <= '0;
      comp_r       <= 2'd0;
      bcnt_r       <= 4'd0;
      brt_r        <= BRIGHT_RST;
      out_strobe_r <= 1'b0;
      out_data_r   <= '0;
    end else begin
      st_r         <= st_nxt;
      pix_r        <= pix_nxt;
      comp_r       <= comp_nxt;
      bcnt_r       <= bcnt_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_data_r   <= out_data_nxt;
      if (cfg_we) begin
        brt_r <= cfg_wdata;
      end
    end
  end

  // Hold the item and form the blend products
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
      idx_r  <= idx_in;
    end
    if (st_r == S_BLEND_MUL) begin
      for (int i = 0; i < 3; i++) begin
        prod_old_r[i] <= {8'd0, old_c[i]} * {8'd0, 8'd255 - item_r.alpha};
        prod_new_r[i] <= {8'd0, new_c[i]} * {8'd0, item_r.alpha};
      end
    end
  end

  // Pixel memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // Valid bits: a pixel never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[mem_waddr] <= 1'b1;
      end
      rd_vld_r <= vld_r[mem_raddr];
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // A beat comes only from a busy state or a terminator accept
  `RFB_ASSERT_NEXT(a_beat_src, clk, rst_n, (st_r == S_IDLE) && !in_acc, !out_strobe_r)
  // The scan position stays within one frame
  `RFB_ASSERT_NOW(a_pix_range, clk, rst_n, 1'b1,
                  (pix_r <= PIXC_W'(NPIX)) && (comp_r <= 2'd2))
  // The end-of-frame position always starts on red
  `RFB_ASSERT_NOW(a_end_comp, clk, rst_n, pix_r == PIXC_W'(NPIX), comp_r == 2'd0)
  // A terminator beat is a lone 255 that closes its item
  `RFB_ASSERT_NOW(a_term_beat, clk, rst_n, out_strobe_r && out_data_r.frame_end,
                  (out_data_r.tx_byte == BYTE_ESC) && out_data_r.last)
  // A blend in S_BLEND_MUL is always followed by its write-back state S_BLEND_WR
  `RFB_ASSERT_NEXT(a_blend_wr, clk, rst_n, st_r == S_BLEND_MUL, st_r == S_BLEND_WR)

endmodule

// ===== dv/rgb_frame_buffer_blend_scanout_unit_tb.sv =====
// Self-checking testbench for the RGB frame buffer with blend and scan-out.
`timescale 1ns / 1ps
module rgb_frame_buffer_blend_scanout_unit_tb;
  import rgbfb_pkg::*;

  // Bytes in one frame, before the terminator.
  localparam int FRAME_BYTES   = 3 * NPIX;
  // Blend keeps the block busy without any beat, so give it
  // this long to finish before touching the brightness register.
  localparam int SETTLE_CYCLES = 8;
  // The limit lies far beyond the slowest correct run.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_MAX    = 10;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  logic       busy;
  in_item_t   in_data   = '0;
  logic       out_strobe;
  out_item_t  out_data;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = '0;

  // Shadow of the block's state, advanced once per accepted item.
  logic [23:0] pix_shadow [NPIX];
  int          scan_pos;
  logic [7:0]  bright_shadow;

  // Beats still owed by the block, oldest first.
  out_item_t   tx_expected [$];

  int mismatches;
  int beats_checked;
  int items_sent;
  int terminators_seen;
  int bright_writes;
  int idle_pct;
  int cycle_count;

  always #6 clk = ~clk;

  rgb_frame_buffer_blend_scanout_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Weighted mix of one color component, rounded down.
  function automatic logic [7:0] blend_component(logic [7:0] old_c, logic [7:0] new_c,
                                                 logic [7:0] a);
    int acc;
    acc = int'(old_c) * (255 - int'(a)) + int'(new_c) * int'(a);
    return 8'(acc >> 8);
  endfunction

  function automatic void queue_beat(logic [7:0] tx, logic fend, logic lst);
    out_item_t beat;
    beat.tx_byte   = tx;
    beat.frame_end = fend;
    beat.last      = lst;
    tx_expected.push_back(beat);
  endfunction

  // Apply one accepted item to the shadow state and queue the beats it causes.
  function automatic void predict_tx_bytes(in_item_t it);
    int          idx;
    logic [23:0] old_px;
    logic [7:0]  c;
    case (it.mode)
      MODE_SET, MODE_BLEND: begin
        // Drop writes outside the matrix.
        if (it.row < ROWS && it.col < COLS) begin
          idx = int'(it.row) * COLS + int'(it.col);
          if (it.mode == MODE_BLEND) begin
            old_px = pix_shadow[idx];
            pix_shadow[idx] = {blend_component(old_px[23:16], it.red,   it.alpha),
                               blend_component(old_px[15:8],  it.green, it.alpha),
                               blend_component(old_px[7:0],   it.blue,  it.alpha)};
          end else begin
            pix_shadow[idx] = {it.red, it.green, it.blue};
          end
        end
      end
      MODE_BRIGHT: begin
        // Escape run, command byte, then the register value; scan position holds.
        for (int k = 0; k < int'(ESC_COUNT); k++) queue_beat(BYTE_ESC, 1'b0, 1'b0);
        queue_beat(BYTE_CMD, 1'b0, 1'b0);
        queue_beat(bright_shadow, 1'b0, 1'b1);
      end
      default: begin
        if (scan_pos >= FRAME_BYTES) begin
          // Past the last frame byte: send the terminator and rewind.
          scan_pos = 0;
          terminators_seen++;
          queue_beat(BYTE_ESC, 1'b1, 1'b1);
        end else begin
          // Read the live store, red first; keep 255 reserved for framing.
          c = 8'(pix_shadow[scan_pos / 3] >> (16 - 8 * (scan_pos % 3)));
          if (c == BYTE_ESC) c = BYTE_CLAMP;
          scan_pos++;
          queue_beat(c, 1'b0, 1'b1);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking: every strobed beat is compared with the oldest expectation.
  // ---------------------------------------------------------------------------

  function automatic void flag_beat(string why, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("[%0t] beat %0d %s: expected byte %0d end %b last %b, got byte %0d end %b last %b",
               $realtime, beats_checked, why, want.tx_byte, want.frame_end, want.last,
               got.tx_byte, got.frame_end, got.last);
  endfunction

  always @(posedge clk) begin : check_beats
    out_item_t want;
    // Treat an unknown strobe as a beat, so it cannot slip through unchecked.
    if (rst_n && out_strobe !== 1'b0) begin
      if (tx_expected.size() == 0) begin
        flag_beat("with nothing pending", '0, out_data);
      end else begin
        want = tx_expected.pop_front();
        if (out_strobe !== 1'b1 ||
            out_data.tx_byte !== want.tx_byte ||
            out_data.frame_end !== want.frame_end ||
            out_data.last !== want.last)
          flag_beat("differs", want, out_data);
      end
      beats_checked++;
    end
  end

  // Hang guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still pending", cycle_count,
               tx_expected.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Hand one item to the block: idle at random first, then hold start until the
  // block takes it. Start stays high on return so back-to-back items stream.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_tx_bytes(it);
    items_sent++;
  endtask

  // Drop start, wait for every owed beat, then let a trailing blend finish.
  task automatic settle();
    start <= 1'b0;
    while (tx_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes only go in while the block is idle.
  task automatic write_brightness(input logic [7:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we        <= 1'b0;
    bright_shadow  = value;
    bright_writes++;
  endtask

  function automatic in_item_t make_item(logic [1:0] m, logic [3:0] r, logic [3:0] c,
                                         logic [7:0] a, logic [7:0] rd, logic [7:0] gr,
                                         logic [7:0] bl);
    in_item_t it;
    it.mode  = m;
    it.row   = r;
    it.col   = c;
    it.alpha = a;
    it.red   = rd;
    it.green = gr;
    it.blue  = bl;
    return it;
  endfunction

  // Favor the end values, where clamping and rounding bite.
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 3))
      0:       return 8'hFF;
      1:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly in-matrix coordinates, with a share beyond the edge.
  function automatic logic [3:0] pick_coord(int extent);
    if ($urandom_range(0, 4) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, extent - 1));
  endfunction

  function automatic in_item_t random_pixel_write();
    return make_item($urandom_range(0, 1) ? MODE_BLEND : MODE_SET,
                     pick_coord(ROWS), pick_coord(COLS), pick_level(),
                     pick_level(), pick_level(), pick_level());
  endfunction

  // Scan-heavy mix so the random part walks through frame ends too.
  function automatic in_item_t random_item();
    in_item_t it;
    int       w;
    it = random_pixel_write();
    w  = $urandom_range(0, 99);
    if (w < 55)      it.mode = MODE_SCAN;
    else if (w < 93) it.mode = it.mode;
    else             it.mode = MODE_BRIGHT;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, each mode, writes outside the matrix, blend at both weight
  // ends, and the 255-to-254 clamp on the scan path.
  task automatic test_directed();
    idle_pct = 0;
    send_item(make_item(MODE_SCAN,   4'd0,  4'd0,  8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_BRIGHT, 4'd0,  4'd0,  8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_SET,    4'd0,  4'd0,  8'h00, 8'hFF, 8'h00, 8'h80));
    send_item(make_item(MODE_SET,    4'd7,  4'd7,  8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(MODE_SET,    4'd8,  4'd0,  8'h00, 8'h11, 8'h22, 8'h33));
    send_item(make_item(MODE_SET,    4'd0,  4'd8,  8'h00, 8'h44, 8'h55, 8'h66));
    send_item(make_item(MODE_SET,    4'd15, 4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(MODE_SET,    4'd8,  4'd8,  8'h00, 8'h77, 8'h88, 8'h99));
    send_item(make_item(MODE_BLEND,  4'd0,  4'd0,  8'h00, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(MODE_BLEND,  4'd0,  4'd0,  8'hFF, 8'h00, 8'hFF, 8'h01));
    send_item(make_item(MODE_BLEND,  4'd7,  4'd7,  8'h80, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_BLEND,  4'd15, 4'd3,  8'h80, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(MODE_SET,    4'd0,  4'd1,  8'h00, 8'hFF, 8'hFF, 8'hFF));
    repeat (6) send_item(make_item(MODE_SCAN, 4'd15, 4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(MODE_BRIGHT, 4'd15, 4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    settle();
  endtask

  // Brightness command at both register extremes and one value in between.
  task automatic test_brightness_register();
    logic [7:0] mid;
    mid = 8'($urandom_range(1, 254));
    idle_pct = 0;
    write_brightness(8'h00);
    send_item(make_item(MODE_BRIGHT, 4'd0, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    write_brightness(8'hFF);
    send_item(make_item(MODE_BRIGHT, 4'd0, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    write_brightness(mid);
    send_item(make_item(MODE_BRIGHT, 4'd0, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    settle();
  endtask

  // Scan through the rest of the frame, past the terminator and into the next,
  // with pixel writes landing ahead of and behind the scan position.
  task automatic test_frame_wrap(input int pct);
    int scans_left;
    idle_pct   = pct;
    scans_left = FRAME_BYTES - scan_pos + 1 + 4;
    while (scans_left > 0) begin
      if ($urandom_range(0, 3) == 0) send_item(random_pixel_write());
      send_item(make_item(MODE_SCAN, 4'($urandom), 4'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom)));
      scans_left--;
    end
    settle();
  endtask

  task automatic test_random_traffic(input int pct, input int count,
                                     input logic [7:0] bright);
    write_brightness(bright);
    idle_pct = pct;
    repeat (count) send_item(random_item());
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < NPIX; i++) pix_shadow[i] = '0;
    scan_pos         = 0;
    bright_shadow    = BRIGHT_RST;
    mismatches       = 0;
    beats_checked    = 0;
    items_sent       = 0;
    terminators_seen = 0;
    bright_writes    = 0;
    idle_pct         = 0;
    cycle_count      = 0;

    // Hold reset low, then release it on an edge.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_brightness_register();
    test_random_traffic(0,  45, 8'hFF);
    test_random_traffic(45, 45, 8'h00);
    test_frame_wrap(45);
    test_random_traffic(32, 45, 8'($urandom_range(1, 254)));
    test_random_traffic(0,  45, 8'h80);

    // Let any late beat show up before judging.
    settle();
    repeat (20) @(posedge clk);
    mismatches += tx_expected.size();

    $display("Covered %0d items and %0d beats, %0d frame terminators, %0d brightness writes",
             items_sent, beats_checked, terminators_seen, bright_writes);
    $display("Modes set, blend, brightness and scan under idle rates 0, 45 and 32 percent");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d failing beats", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
